@@ rtl/b64d_pkg.sv @@
// b64d_pkg: item types, status codes and character decode for the base64 decoder
// no dependencies; imported by base64url_stream_decoder, b64d_props, b64d_checker and tb
package b64d_pkg;

  // item status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SKIP = 2'd1,
    ST_PAD  = 2'd2,
    ST_ERR  = 2'd3
  } status_t;

  // alphabet offsets
  localparam logic [5:0] LOWER_BASE = 6'd26;
  localparam logic [5:0] DIGIT_BASE = 6'd52;
  localparam logic [5:0] VAL_DASH   = 6'd62;
  localparam logic [5:0] VAL_SCORE  = 6'd63;

  // special characters
  localparam logic [7:0] CH_PAD = 8'h3D;  // '='
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  typedef struct packed {
    logic [7:0] char_in;
    logic       first_char;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    status_t    status;
    logic       end_of_string;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sextet_t;

  // map one character to its 6-bit value, ok low outside both alphabets
  function automatic sextet_t sextet_of(logic [7:0] ch);
    sextet_t s;
    logic [7:0] d;
    s.ok    = 1'b1;
    s.value = '0;
    d       = '0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      d = ch - 8'h41;
      s.value = d[5:0];
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      d = ch - 8'h61;
      s.value = d[5:0] + LOWER_BASE;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      d = ch - 8'h30;
      s.value = d[5:0] + DIGIT_BASE;
    end else if (ch == 8'h2D || ch == 8'h2B) begin
      s.value = VAL_DASH;
    end else if (ch == 8'h5F || ch == 8'h2F) begin
      s.value = VAL_SCORE;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

@@ rtl/base64url_stream_decoder.sv @@
// base64url_stream_decoder: streaming base64 / base64url character decoder
// depends on b64d_pkg
// an accepted item passes the input reg, then the result reg
// throughput: one item per cycle; in_stall only while both regs are full and out_stall is high
// reset: synchronous active-low rst_n clears both pipeline valids and the decode state
module base64url_stream_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  b64d_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output b64d_pkg::out_item_t out_item
);
  import b64d_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic [11:0] buf_r, buf_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic        pad_r, pad_nxt;
  logic        err_r, err_nxt;

  logic s1_move, s1_fire, in_fire;

  // handshake: input reg moves when the result reg is empty or being taken
  assign s1_move  = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_move;
  assign in_stall = s1_valid_r && !s1_move;
  assign in_fire  = in_valid && !in_stall;

  // decode datapath
  logic [11:0] buf_cur, buf_sh;
  logic [2:0]  pend_cur, shift;
  logic        pad_cur, err_cur;
  logic [3:0]  bits;
  sextet_t     sx;
  logic [11:0] buf_upd;
  logic [2:0]  pend_upd;
  logic        pad_upd, err_upd;
  out_item_t   res;

  always_comb begin
    // a first character starts from cleared state
    buf_cur  = s1_item_r.first_char ? '0 : buf_r;
    pend_cur = s1_item_r.first_char ? '0 : pend_r;
    pad_cur  = s1_item_r.first_char ? 1'b0 : pad_r;
    err_cur  = s1_item_r.first_char ? 1'b0 : err_r;

    sx     = sextet_of(s1_item_r.char_in);
    buf_sh = {buf_cur[5:0], sx.value};
    bits   = {1'b0, pend_cur} + 4'd6;
    shift  = bits[2:0];

    buf_upd  = buf_cur;
    pend_upd = pend_cur;
    pad_upd  = pad_cur;
    err_upd  = err_cur;

    res.byte_valid    = 1'b0;
    res.data_byte     = '0;
    res.status        = ST_OK;
    res.end_of_string = s1_item_r.last_char;

    if (err_cur) begin
      res.status = ST_ERR;
    end else if (pad_cur) begin
      res.status = ST_PAD;
    end else if (s1_item_r.char_in == CH_PAD) begin
      pad_upd    = 1'b1;
      res.status = ST_PAD;
    end else if (s1_item_r.char_in == CH_CR || s1_item_r.char_in == CH_LF) begin
      res.status = ST_SKIP;
    end else if (!sx.ok) begin
      err_upd    = 1'b1;
      res.status = ST_ERR;
    end else begin
      buf_upd = buf_sh;
      // a byte is ready once 8 or more bits are pending
      if (bits[3]) begin
        res.byte_valid = 1'b1;
        pend_upd       = shift;
        case (shift)
          3'd2:    res.data_byte = buf_sh[9:2];
          3'd4:    res.data_byte = buf_sh[11:4];
          default: res.data_byte = buf_sh[7:0];
        endcase
      end else begin
        pend_upd = shift;
      end
    end
  end

  // next values for pipeline and decode state
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    buf_nxt       = buf_r;
    pend_nxt      = pend_r;
    pad_nxt       = pad_r;
    err_nxt       = err_r;

    if (!in_stall) begin
      s1_valid_nxt = in_fire;
    end
    if (!out_valid_r || !out_stall) begin
      out_valid_nxt = s1_valid_r;
    end
    if (s1_fire) begin
      out_item_nxt = res;
      // the last character leaves the state cleared
      if (s1_item_r.last_char) begin
        buf_nxt  = '0;
        pend_nxt = '0;
        pad_nxt  = 1'b0;
        err_nxt  = 1'b0;
      end else begin
        buf_nxt  = buf_upd;
        pend_nxt = pend_upd;
        pad_nxt  = pad_upd;
        err_nxt  = err_upd;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      buf_r       <= '0;
      pend_r      <= '0;
      pad_r       <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      buf_r       <= buf_nxt;
      pend_r      <= pend_nxt;
      pad_r       <= pad_nxt;
      err_r       <= err_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/b64d_checker.sv @@
// b64d_props: port-level assertions for base64url_stream_decoder, bound below
// depends on b64d_pkg
module b64d_props (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input b64d_pkg::out_item_t out_item
);
  import b64d_pkg::*;

  // stalled result stays valid
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result valid dropped while stalled");

  // stalled result payload holds
  a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_item))
    else $error("result item changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a byte only comes with an accepted character
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.byte_valid |-> out_item.status == ST_OK)
    else $error("byte emitted with non-ok status");

  // data is zero when no byte is emitted
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.byte_valid |-> out_item.data_byte == 8'd0)
    else $error("data byte nonzero without byte_valid");

endmodule

bind base64url_stream_decoder b64d_props u_b64d_checker (.*);

@@ verif/b64d_checker.sv @@
// b64d_checker: watches both channels of the base64 decoder, predicts each result item and compares
// depends on b64d_pkg for the item structs, status codes and special characters
`timescale 1ns / 100ps

module b64d_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  b64d_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  b64d_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending
);
  import b64d_pkg::*;

  localparam int MAX_REPORTS = 64;

  // decode state of the string in progress
  logic [11:0] acc_bits;
  logic [2:0]  acc_count;
  logic        pad_hit;
  logic        bad_char;

  out_item_t decoded_q[$];

  // 6-bit value of a character, bit 6 set when it belongs to either alphabet
  function automatic logic [6:0] char_value(logic [7:0] ch);
    logic [7:0] v;
    v = 8'h00;
    if (ch >= 8'h41 && ch <= 8'h5A) v = ch - 8'h41;          // A..Z
    else if (ch >= 8'h61 && ch <= 8'h7A) v = ch - 8'h61 + 8'd26;  // a..z
    else if (ch >= 8'h30 && ch <= 8'h39) v = ch - 8'h30 + 8'd52;  // 0..9
    else if (ch == 8'h2D || ch == 8'h2B) v = 8'd62;          // '-' or '+'
    else if (ch == 8'h5F || ch == 8'h2F) v = 8'd63;          // '_' or '/'
    else return 7'h00;
    return {1'b1, v[5:0]};
  endfunction

  function automatic void clear_string();
    acc_bits  = '0;
    acc_count = '0;
    pad_hit   = 1'b0;
    bad_char  = 1'b0;
  endfunction

  // advance the decode state by one character and build its result item
  function automatic out_item_t decode_char(in_item_t it);
    out_item_t  r;
    logic [6:0] cv;
    logic [3:0] nbits;
    logic [11:0] shifted;
    r = '0;
    r.end_of_string = it.last_char;
    if (it.first_char) clear_string();
    if (bad_char) begin
      r.status = ST_ERR;
    end else if (pad_hit) begin
      r.status = ST_PAD;
    end else if (it.char_in == CH_PAD) begin
      pad_hit  = 1'b1;
      r.status = ST_PAD;
    end else if (it.char_in == CH_CR || it.char_in == CH_LF) begin
      r.status = ST_SKIP;
    end else begin
      cv = char_value(it.char_in);
      if (!cv[6]) begin
        bad_char = 1'b1;
        r.status = ST_ERR;
      end else begin
        acc_bits = {acc_bits[5:0], cv[5:0]};
        nbits    = {1'b0, acc_count} + 4'd6;
        if (nbits >= 4'd8) begin
          nbits        = nbits - 4'd8;
          shifted      = acc_bits >> nbits;
          r.data_byte  = shifted[7:0];
          r.byte_valid = 1'b1;
        end
        acc_count = nbits[2:0];
        r.status  = ST_OK;
      end
    end
    // string closed: leftover bits are dropped
    if (it.last_char) clear_string();
    return r;
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
    end
  endfunction

  // sample accepted items on both channels
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      clear_string();
      decoded_q.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (in_valid && !in_stall)
        decoded_q.push_back(decode_char(in_item));
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $error("result item with no decoded item waiting");
        end else begin
          want = decoded_q.pop_front();
          check_field("byte_valid", {7'd0, want.byte_valid}, {7'd0, out_item.byte_valid});
          check_field("data_byte", want.data_byte, out_item.data_byte);
          check_field("status", {6'd0, want.status}, {6'd0, out_item.status});
          check_field("end_of_string", {7'd0, want.end_of_string},
                      {7'd0, out_item.end_of_string});
        end
      end
      pending <= decoded_q.size();
    end
  end

endmodule

@@ verif/tb.sv @@
// tb: drives character strings into base64url_stream_decoder with random gaps and stalls
// depends on b64d_pkg, base64url_stream_decoder and b64d_checker
`timescale 1ns / 100ps

module tb;
  import b64d_pkg::*;

  localparam int STUCK_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 500;
  localparam int DRAIN_CYCLES  = 4;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int fail_count;
  int pending;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int items_sent   = 0;
  int stuck_cycles = 0;

  base64url_stream_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  b64d_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // cycles since the last item moved on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // random character from either alphabet
  function automatic logic [7:0] alphabet_char();
    int idx;
    idx = $urandom_range(63);
    if (idx < 26) return 8'(8'h41 + idx);
    if (idx < 52) return 8'(8'h61 + idx - 26);
    if (idx < 62) return 8'(8'h30 + idx - 52);
    if (idx == 62) return $urandom_range(1) ? 8'h2D : 8'h2B;
    return $urandom_range(1) ? 8'h5F : 8'h2F;
  endfunction

  // offer one item, idling first at random, and hold it until accepted
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] ch, input logic first, input logic last);
    in_item_t it;
    it.char_in    = ch;
    it.first_char = first;
    it.last_char  = last;
    send_item(it);
  endtask

  task automatic send_str(input string s, input logic first, input logic last);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], first && i == 0, last && i == s.len() - 1);
  endtask

  // one string: mostly well formed, some broken, some pure noise
  task automatic send_random_string();
    in_item_t q[$];
    in_item_t it;
    int kind;
    int len;
    int npad;
    kind = $urandom_range(99);
    len  = $urandom_range(16, 1);
    for (int i = 0; i < len; i++) begin
      it = '0;
      if (kind >= 85) begin
        it.char_in    = 8'($urandom_range(255));
        it.first_char = ($urandom_range(7) == 0);
        it.last_char  = ($urandom_range(7) == 0);
      end else if ($urandom_range(11) == 0) begin
        it.char_in = $urandom_range(1) ? CH_CR : CH_LF;
      end else begin
        it.char_in = alphabet_char();
      end
      q.push_back(it);
    end
    if (kind < 85) begin
      // optional padding, sometimes with junk behind it
      if ($urandom_range(3) == 0) begin
        npad = $urandom_range(2, 1);
        for (int i = 0; i < npad; i++) begin
          it = '0;
          it.char_in = CH_PAD;
          q.push_back(it);
        end
        if ($urandom_range(3) == 0) begin
          it = '0;
          it.char_in = 8'($urandom_range(255));
          q.push_back(it);
        end
      end
      if (kind >= 70) begin
        q[$urandom_range(q.size() - 1)].char_in = 8'($urandom_range(255));
        q[0].first_char = 1'($urandom_range(1));
        q[q.size() - 1].last_char = 1'($urandom_range(1));
      end else begin
        q[0].first_char = 1'b1;
        q[q.size() - 1].last_char = 1'b1;
      end
    end
    foreach (q[i]) send_item(q[i]);
  endtask

  initial begin
    int target;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed strings
    send_str("TWFu", 1'b1, 1'b1);
    // both alphabets with CR and LF skipped, string left open
    send_str("_-\r/+\n9", 1'b1, 1'b0);
    // new string started without closing the old one
    send_str("0aZz", 1'b1, 1'b1);
    // invalid character after padding still reports padding
    send_str("QQ=*", 1'b1, 1'b1);
    // error wins over padding, extreme character codes
    send_char(8'h41, 1'b1, 1'b0);
    send_char(8'h00, 1'b0, 1'b0);
    send_char(CH_PAD, 1'b0, 1'b0);
    send_char(8'hFF, 1'b0, 1'b1);
    // one-character string
    send_str("Y", 1'b1, 1'b1);
    // fresh string after last_char without first_char
    send_str("Zg", 1'b0, 1'b1);

    // random strings under changing flow control
    target = items_sent;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      target += PHASE_ITEMS;
      while (items_sent < target) send_random_string();
    end
    in_valid <= 1'b0;

    // drain outstanding results
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
